// ----- hdl/rau_pkg.sv -----
package rau_pkg;

    localparam int OPW       = 32;
    localparam int PW        = 2 * OPW;
    localparam int AW        = PW + 1;
    localparam int CW        = $clog2(PW);
    localparam int FIELD_W   = 32;
    localparam int CMD_W     = 2;
    localparam int RES_NUM_W = 64;
    localparam int RES_DEN_W = 63;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD,
        CMD_SUB,
        CMD_MUL,
        CMD_DIV
    } t_cmd;

    typedef struct packed {
        logic           neg;
        logic [OPW-1:0] mag;
    } t_sm;

    typedef struct packed {
        logic [AW-1:0] a;
        logic [AW-1:0] b;
        logic          sub;
    } t_alu_in;

    typedef struct packed {
        logic [AW-1:0] y;
        logic          carry;
    } t_alu_out;

    function automatic t_sm take_operand(input logic [OPW-1:0] raw);
        t_sm r;
        r.neg = raw[OPW-1];
        r.mag = r.neg ? (~raw + OPW'(1)) : raw;
        return r;
    endfunction

endpackage

// ----- hdl/rau_if.sv -----
interface rau_req_if import rau_pkg::*;;
    logic                      valid;
    logic                      ready;
    logic        [CMD_W-1:0]   cmd;
    logic signed [FIELD_W-1:0] a_num;
    logic signed [FIELD_W-1:0] a_den;
    logic signed [FIELD_W-1:0] b_num;
    logic signed [FIELD_W-1:0] b_den;

    modport source (output valid, cmd, a_num, a_den, b_num, b_den, input ready);
    modport sink   (input valid, cmd, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_rsp_if import rau_pkg::*;;
    logic                        valid;
    logic                        ready;
    logic signed [RES_NUM_W-1:0] res_num;
    logic        [RES_DEN_W-1:0] res_den;
    logic                        err;

    modport source (output valid, res_num, res_den, err, input ready);
    modport sink   (input valid, res_num, res_den, err, output ready);
endinterface

// ----- hdl/rational_arith_unit_top.sv -----
// Flow: an error goes straight to the result and a zero result skips the gcd; otherwise
// the products on the shared 32x32 multiplier, a binary gcd on the shared 65-bit
// subtractor (one shift, swap or subtract per cycle), then two restoring divisions by
// the gcd on the same subtractor.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous, active low; returns to idle and drops the result valid.
module rational_arith_unit_top import rau_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_req_if.sink   i_req,
    rau_rsp_if.source o_rsp
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_COMB,
        S_NEG,
        S_CHK,
        S_TZ,
        S_GCD,
        S_DIVN,
        S_DIVD,
        S_SIGN,
        S_OUT
    } t_state;

    localparam logic [CW-1:0] LAST = CW'(PW - 1);

    t_state                r_state;
    t_cmd                  r_cmd;
    logic [OPW-1:0]        r_an, r_ad, r_bn, r_bd;
    logic                  r_s0, r_s1, r_sden, r_nneg;
    logic [PW-1:0]         r_u, r_v, r_w, r_n, r_d, r_rem;
    logic [CW-1:0]         r_cnt;
    logic [RES_NUM_W-1:0]  r_res_num;
    logic [RES_DEN_W-1:0]  r_res_den;
    logic                  r_res_err;
    logic [RES_NUM_W-1:0]  r_o_num;
    logic [RES_DEN_W-1:0]  r_o_den;
    logic                  r_o_err;
    logic                  r_o_valid;

    t_sm           in_an, in_ad, in_bn, in_bd;
    t_cmd          in_cmd;
    logic          in_err;
    logic [OPW-1:0] mul_x, mul_y;
    logic [PW-1:0] prod;
    t_alu_in       alu_i;
    t_alu_out      alu_o;
    logic [AW-1:0] rem_sh;
    logic [PW-1:0] quot;
    logic [PW-1:0] rem_nxt;
    logic [PW-1:0] num_out;

    assign in_cmd = t_cmd'(i_req.cmd);
    assign in_an  = take_operand(i_req.a_num[OPW-1:0]);
    assign in_ad  = take_operand(i_req.a_den[OPW-1:0]);
    assign in_bn  = take_operand(i_req.b_num[OPW-1:0]);
    assign in_bd  = take_operand(i_req.b_den[OPW-1:0]);
    assign in_err = (in_ad.mag == '0) || (in_bd.mag == '0)
                 || ((in_cmd == CMD_DIV) && (in_bn.mag == '0));

    always_comb begin
        case (r_state)
            S_MUL0: begin
                mul_x = r_an;
                mul_y = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            S_MUL1: begin
                mul_x = r_ad;
                mul_y = (r_cmd == CMD_MUL) ? r_bd : r_bn;
            end
            default: begin
                mul_x = r_ad;
                mul_y = r_bd;
            end
        endcase
    end

    rau_mul u_mul (
        .i_clk (i_clk),
        .i_x   (mul_x),
        .i_y   (mul_y),
        .o_p   (prod)
    );

    assign rem_sh = {r_rem, r_u[PW-1]};

    always_comb begin
        case (r_state)
            S_COMB: begin
                alu_i.a   = {1'b0, r_u};
                alu_i.b   = {1'b0, r_v};
                alu_i.sub = r_s0 ^ r_s1;
            end
            S_NEG: begin
                alu_i.a   = '0;
                alu_i.b   = {1'b0, r_u};
                alu_i.sub = 1'b1;
            end
            S_GCD: begin
                alu_i.a   = {1'b0, r_u};
                alu_i.b   = {1'b0, r_v};
                alu_i.sub = 1'b1;
            end
            S_DIVN, S_DIVD: begin
                alu_i.a   = rem_sh;
                alu_i.b   = {1'b0, r_v};
                alu_i.sub = 1'b1;
            end
            S_SIGN: begin
                alu_i.a   = '0;
                alu_i.b   = {1'b0, r_n};
                alu_i.sub = 1'b1;
            end
            default: begin
                alu_i = '0;
            end
        endcase
    end

    rau_alu u_alu (
        .i_op  (alu_i),
        .o_res (alu_o)
    );

    assign quot    = {r_u[PW-2:0], alu_o.carry};
    assign rem_nxt = alu_o.carry ? alu_o.y[PW-1:0] : rem_sh[PW-1:0];
    assign num_out = (r_nneg ^ r_sden) ? alu_o.y[PW-1:0] : r_n;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            if (r_state == S_OUT && (!r_o_valid || o_rsp.ready)) begin
                r_o_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_cmd  <= in_cmd;
                        r_an   <= in_an.mag;
                        r_ad   <= in_ad.mag;
                        r_bn   <= in_bn.mag;
                        r_bd   <= in_bd.mag;
                        r_s0   <= in_an.neg ^ ((in_cmd == CMD_MUL) ? in_bn.neg : in_bd.neg);
                        r_s1   <= in_bn.neg ^ in_ad.neg ^ (in_cmd == CMD_SUB);
                        r_sden <= in_ad.neg ^ ((in_cmd == CMD_DIV) ? in_bn.neg : in_bd.neg);
                        if (in_err) begin
                            r_res_num <= '0;
                            r_res_den <= '0;
                            r_res_err <= 1'b1;
                            r_state   <= S_OUT;
                        end else begin
                            r_state <= S_MUL0;
                        end
                    end
                end
                S_MUL0: begin
                    r_state <= S_MUL1;
                end
                S_MUL1: begin
                    r_u     <= prod;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_v <= prod;
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        r_state <= S_MUL3;
                    end else begin
                        r_nneg  <= r_s0;
                        r_state <= S_CHK;
                    end
                end
                S_MUL3: begin
                    r_w     <= prod;
                    r_state <= S_COMB;
                end
                S_COMB: begin
                    r_u <= alu_o.y[PW-1:0];
                    r_v <= r_w;
                    if (alu_i.sub && !alu_o.carry) begin
                        r_nneg  <= r_s1;
                        r_state <= S_NEG;
                    end else begin
                        r_nneg  <= r_s0;
                        r_state <= S_CHK;
                    end
                end
                S_NEG: begin
                    r_u     <= alu_o.y[PW-1:0];
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    if (r_u == '0) begin
                        r_res_num <= '0;
                        r_res_den <= RES_DEN_W'(1);
                        r_res_err <= 1'b0;
                        r_state   <= S_OUT;
                    end else begin
                        r_state <= S_TZ;
                    end
                end
                S_TZ: begin
                    // strip common powers of two from both
                    if (!r_u[0] && !r_v[0]) begin
                        r_u <= r_u >> 1;
                        r_v <= r_v >> 1;
                    end else begin
                        r_n     <= r_u;
                        r_d     <= r_v;
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (!r_u[0]) begin
                        r_u <= r_u >> 1;
                    end else if (!r_v[0]) begin
                        r_v <= r_v >> 1;
                    end else if (r_u == r_v) begin
                        // r_v holds the gcd from here on
                        r_u     <= r_n;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVN;
                    end else if (!alu_o.carry) begin
                        r_u <= r_v;
                        r_v <= r_u;
                    end else begin
                        r_u <= alu_o.y[PW-1:0];
                    end
                end
                S_DIVN: begin
                    if (r_cnt == LAST) begin
                        r_n     <= quot;
                        r_u     <= r_d;
                        r_rem   <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIVD;
                    end else begin
                        r_u   <= quot;
                        r_rem <= rem_nxt;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DIVD: begin
                    if (r_cnt == LAST) begin
                        r_d     <= quot;
                        r_cnt   <= '0;
                        r_state <= S_SIGN;
                    end else begin
                        r_u   <= quot;
                        r_rem <= rem_nxt;
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_SIGN: begin
                    r_res_num <= RES_NUM_W'(signed'(num_out));
                    r_res_den <= RES_DEN_W'(r_d);
                    r_res_err <= 1'b0;
                    r_state   <= S_OUT;
                end
                S_OUT: begin
                    if (!r_o_valid || o_rsp.ready) begin
                        r_o_num   <= r_res_num;
                        r_o_den   <= r_res_den;
                        r_o_err   <= r_res_err;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_o_valid;
    assign o_rsp.res_num = r_o_num;
    assign o_rsp.res_den = r_o_den;
    assign o_rsp.err     = r_o_err;

endmodule

// ----- hdl/rau_mul.sv -----
module rau_mul import rau_pkg::*; (
    input  logic           i_clk,
    input  logic [OPW-1:0] i_x,
    input  logic [OPW-1:0] i_y,
    output logic [PW-1:0]  o_p
);

    logic [PW-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= PW'(i_x) * PW'(i_y);
    end

    assign o_p = r_p;

endmodule

// ----- hdl/rau_alu.sv -----
module rau_alu import rau_pkg::*; (
    input  t_alu_in  i_op,
    output t_alu_out o_res
);

    logic [AW-1:0] b_eff;
    logic [AW:0]   full;

    assign b_eff = i_op.sub ? ~i_op.b : i_op.b;
    assign full  = {1'b0, i_op.a} + {1'b0, b_eff} + (AW + 1)'(i_op.sub);

    assign o_res.y     = full[AW-1:0];
    assign o_res.carry = full[AW];

endmodule
